// File: hdl/lbg_pkg.sv
`default_nettype none

package lbg_pkg;

  // Full scale of the Q8.8 level: 100.0 percent
  localparam int FULL_LEVEL = 25600;

  localparam int LEVEL_W = 16;
  localparam int WORD_W  = 32;
  localparam int MASK_W  = 9;
  localparam int BEAM_W  = 4;

  localparam logic [WORD_W-1:0] START_WORD = '0;
  localparam logic [WORD_W-1:0] END_WORD   = 32'hffff_ffff;

  // Default geometry of the bar graph
  localparam int NUM_BEAMS_DEF   = 9;
  localparam int BEAM_LENGTH_DEF = 13;
  localparam int LED_TOTAL_DEF   = 119;

  localparam logic [MASK_W-1:0] REVERSE_MASK_RST = 9'd170;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_LOW  = 3'd0,
    CFG_COLOR_MID  = 3'd1,
    CFG_COLOR_HIGH = 3'd2,
    CFG_COLOR_OFF  = 3'd3,
    CFG_REV_MASK   = 3'd4
  } cfg_idx_e;

  // Position of the emitter within one beam's words
  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_PIX   = 4'b0010,
    PH_SPARE = 4'b0100,
    PH_END   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] mid;
    logic [WORD_W-1:0] high;
    logic [WORD_W-1:0] off;
  } colors_t;

  // One beam waiting in the input register
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               rev;
    logic               first;
    logic               last_beam;
  } job_t;

endpackage

`default_nettype wire

// File: hdl/lbg_in.sv
`default_nettype none

module lbg_in import lbg_pkg::*; #(
  parameter int NUM_BEAMS = NUM_BEAMS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [LEVEL_W-1:0] level_i,
  output logic                    in_stall_o,
  input  wire logic [MASK_W-1:0]  reverse_mask_i,
  input  wire logic               pop_i,
  output logic                    job_valid_o,
  output job_t                    job_o
);

  localparam logic [BEAM_W-1:0] LastBeam = BEAM_W'(NUM_BEAMS - 1);

  logic              vld_q, vld_d;
  logic [BEAM_W-1:0] beam_q, beam_d;
  job_t              job_q, job_d;
  logic              accept;
  logic [(1 << BEAM_W)-1:0] mask_ext;

  // Take a new word when the register is empty or drains this cycle
  assign in_stall_o = vld_q && !pop_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Beams past the mask width have no mask bit and fill normally
  assign mask_ext = {{((1 << BEAM_W) - MASK_W){1'b0}}, reverse_mask_i};

  always_comb begin
    vld_d  = vld_q;
    beam_d = beam_q;
    job_d  = job_q;
    if (pop_i) begin
      vld_d = 1'b0;
    end
    if (accept) begin
      vld_d           = 1'b1;
      job_d.level     = level_i;
      job_d.rev       = mask_ext[beam_q];
      job_d.first     = (beam_q == '0);
      job_d.last_beam = (beam_q == LastBeam);
      beam_d          = (beam_q == LastBeam) ? '0 : beam_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beam_q <= '0;
    end else begin
      vld_q  <= vld_d;
      beam_q <= beam_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = vld_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

// File: hdl/lbg_emit.sv
`default_nettype none

module lbg_emit import lbg_pkg::*; #(
  parameter int NUM_BEAMS   = NUM_BEAMS_DEF,
  parameter int BEAM_LENGTH = BEAM_LENGTH_DEF,
  parameter int LED_TOTAL   = LED_TOTAL_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  wire job_t              job_i,
  input  wire colors_t           colors_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      led_word_o,
  output logic                   last_o
);

  localparam int Used      = NUM_BEAMS * BEAM_LENGTH;
  localparam int SpareN    = (LED_TOTAL > Used) ? (LED_TOTAL - Used) : 0;
  localparam int SpareLast = (SpareN > 0) ? (SpareN - 1) : 0;
  localparam int CntMax    = (BEAM_LENGTH > SpareN) ? BEAM_LENGTH : SpareN;
  localparam int CNT_W     = (CntMax > 1) ? $clog2(CntMax) : 1;
  localparam int TW        = $clog2(BEAM_LENGTH + 1);
  // Smallest lit counts that reach the mid and high colours
  localparam int LitMid    = (34 * BEAM_LENGTH + 99) / 100;
  localparam int LitHigh   = (67 * BEAM_LENGTH + 99) / 100;

  // thr[k]: smallest level that lights at least k LEDs
  logic [LEVEL_W-1:0] thr [1 << TW];

  for (genvar k = 0; k < (1 << TW); k++) begin : g_thr
    localparam int Thr = (k <= BEAM_LENGTH) ?
                         ((k * FULL_LEVEL + BEAM_LENGTH - 1) / BEAM_LENGTH) : 65535;
    assign thr[k] = LEVEL_W'(Thr);
  end

  phase_e            phase_q, phase_d, cur;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              last_q, last_d;
  logic              load, done;
  logic [TW-1:0]     pix, idx;
  logic              on;
  logic [WORD_W-1:0] color;

  // Output register frees when empty or taken this cycle
  assign load  = job_valid_i && (!out_vld_q || !out_stall_i);
  assign pop_o = load && done;

  // Pick the beam colour from its lit count
  always_comb begin
    if (job_i.level < thr[LitMid]) begin
      color = colors_i.low;
    end else if (job_i.level < thr[LitHigh]) begin
      color = colors_i.mid;
    end else begin
      color = colors_i.high;
    end
  end

  // Decide whether this LED is lit; reversed beams light from the far end
  assign pix = TW'(cnt_q);
  assign idx = job_i.rev ? (TW'(BEAM_LENGTH) - pix) : (pix + 1'b1);
  assign on  = (job_i.level >= thr[idx]);

  // Skip the start word on all but the first beam
  assign cur = (phase_q == PH_START && !job_i.first) ? PH_PIX : phase_q;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    last_d  = last_q;
    done    = 1'b0;
    unique case (cur)
      PH_START: begin
        word_d  = START_WORD;
        last_d  = 1'b0;
        phase_d = PH_PIX;
        cnt_d   = '0;
      end
      PH_PIX: begin
        word_d = on ? color : colors_i.off;
        last_d = 1'b0;
        if (cnt_q == CNT_W'(BEAM_LENGTH - 1)) begin
          cnt_d = '0;
          if (!job_i.last_beam) begin
            last_d  = 1'b1;
            done    = 1'b1;
            phase_d = PH_START;
          end else if (SpareN > 0) begin
            phase_d = PH_SPARE;
          end else begin
            phase_d = PH_END;
          end
        end else begin
          cnt_d   = cnt_q + 1'b1;
          phase_d = PH_PIX;
        end
      end
      PH_SPARE: begin
        word_d = colors_i.off;
        last_d = 1'b0;
        if (cnt_q == CNT_W'(SpareLast)) begin
          cnt_d   = '0;
          phase_d = PH_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      PH_END: begin
        word_d  = END_WORD;
        last_d  = 1'b1;
        done    = 1'b1;
        cnt_d   = '0;
        phase_d = PH_START;
      end
      default: begin
        phase_d = PH_START;
        cnt_d   = '0;
      end
    endcase
  end

  // Hold the word while stalled, drop it once taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (load) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign led_word_o  = word_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// File: hdl/led_bar_graph_renderer.sv
// A level word is registered in lbg_in and its LED words in the lbg_emit output register.
// Throughput: one LED word per cycle while a level waits and out_stall_i is low; a beam
// gives BEAM_LENGTH words, plus the start word on beam 0 and the spare LEDs and end word
// on the last beam. The next level is taken in the cycle its predecessor's last word is
// produced. Reset: beam index, valid flags and sequencer clear; colours to 0, mask to 170.
`default_nettype none

module led_bar_graph_renderer import lbg_pkg::*; #(
  parameter int NUM_BEAMS   = NUM_BEAMS_DEF,
  parameter int BEAM_LENGTH = BEAM_LENGTH_DEF,
  parameter int LED_TOTAL   = LED_TOTAL_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [LEVEL_W-1:0]   level_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [WORD_W-1:0]         led_word_o,
  output logic                      last_o
);

  colors_t           colors_q, colors_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic              job_valid, pop;
  job_t              job;

  // Decode register writes
  always_comb begin
    colors_d = colors_q;
    mask_d   = mask_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_LOW:  colors_d.low  = cfg_wdata_i;
        CFG_COLOR_MID:  colors_d.mid  = cfg_wdata_i;
        CFG_COLOR_HIGH: colors_d.high = cfg_wdata_i;
        CFG_COLOR_OFF:  colors_d.off  = cfg_wdata_i;
        CFG_REV_MASK:   mask_d        = cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q <= '0;
      mask_q   <= REVERSE_MASK_RST;
    end else begin
      colors_q <= colors_d;
      mask_q   <= mask_d;
    end
  end

  lbg_in #(
    .NUM_BEAMS (NUM_BEAMS)
  ) u_in (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .level_i        (level_i),
    .in_stall_o     (in_stall_o),
    .reverse_mask_i (mask_q),
    .pop_i          (pop),
    .job_valid_o    (job_valid),
    .job_o          (job)
  );

  lbg_emit #(
    .NUM_BEAMS   (NUM_BEAMS),
    .BEAM_LENGTH (BEAM_LENGTH),
    .LED_TOTAL   (LED_TOTAL)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .colors_i    (colors_q),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_word_o  (led_word_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbg_pkg::*;

  localparam int NUM_BEAMS    = NUM_BEAMS_DEF;
  localparam int BEAM_LENGTH  = BEAM_LENGTH_DEF;
  localparam int LED_TOTAL    = LED_TOTAL_DEF;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT_NS = 400000;

  // Register indexes past the end of the map: writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } strip_word_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [WORD_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [LEVEL_W-1:0] level_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WORD_W-1:0]  led_word_o;
  logic               last_o;

  // Shadow of the block's registers and beam position
  colors_t            shade_regs;
  logic [MASK_W-1:0]  flip_mask;
  int                 beam_no;

  logic [LEVEL_W-1:0] level_q[$];
  strip_word_t        pending_strip_q[$];
  strip_word_t        want;

  int  mismatch_count = 0;
  int  levels_taken   = 0;
  int  words_checked  = 0;
  int  regs_written   = 0;
  int  settings_used  = 0;
  int  tx_gap         = 0;
  int  rx_hold        = 0;
  bit  tx_steady      = 1'b0;
  bit  rx_steady      = 1'b0;
  bit  hold_armed     = 1'b0;
  bit  hold_done      = 1'b0;

  led_bar_graph_renderer #(
    .NUM_BEAMS  (NUM_BEAMS),
    .BEAM_LENGTH(BEAM_LENGTH),
    .LED_TOTAL  (LED_TOTAL)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .level_i    (level_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .led_word_o (led_word_o),
    .last_o     (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] exp);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp, $realtime);
    mismatch_count++;
  endtask

  // Work out every LED word one level word produces and queue them in order
  task automatic render_beam(input logic [LEVEL_W-1:0] lvl);
    int capped;
    int lit;
    int spare;
    int total;
    int n;
    bit flip;
    bit closing;
    bit on;
    logic [WORD_W-1:0] lit_word;
    capped  = (lvl > FULL_LEVEL) ? FULL_LEVEL : int'(lvl);
    lit     = (capped * BEAM_LENGTH) / FULL_LEVEL;
    spare   = (LED_TOTAL > NUM_BEAMS * BEAM_LENGTH) ? LED_TOTAL - NUM_BEAMS * BEAM_LENGTH : 0;
    closing = (beam_no + 1 >= NUM_BEAMS);
    flip    = (beam_no < MASK_W) && flip_mask[beam_no];
    total   = BEAM_LENGTH + ((beam_no == 0) ? 1 : 0) + (closing ? spare + 1 : 0);

    if (lit * 100 < 34 * BEAM_LENGTH) begin
      lit_word = shade_regs.low;
    end else if (lit * 100 < 67 * BEAM_LENGTH) begin
      lit_word = shade_regs.mid;
    end else begin
      lit_word = shade_regs.high;
    end

    n = 0;
    if (beam_no == 0) begin
      n++;
      pending_strip_q.push_back('{word: START_WORD, last: (n == total)});
    end
    for (int k = 0; k < BEAM_LENGTH; k++) begin
      on = flip ? (k >= BEAM_LENGTH - lit) : (k < lit);
      n++;
      pending_strip_q.push_back('{word: on ? lit_word : shade_regs.off, last: (n == total)});
    end
    if (closing) begin
      for (int s = 0; s < spare; s++) begin
        n++;
        pending_strip_q.push_back('{word: shade_regs.off, last: (n == total)});
      end
      n++;
      pending_strip_q.push_back('{word: END_WORD, last: (n == total)});
      beam_no = 0;
    end else begin
      beam_no = beam_no + 1;
    end
  endtask

  // Drive level words from the queue, with random gaps between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        render_beam(level_i);
        levels_taken++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (level_q.size() != 0) begin
          level_i    <= level_q.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
          tx_gap = tx_steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each LED word against the oldest expectation and pace the stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_strip_q.size() == 0) begin
          report_mismatch("LED word with nothing expected", led_word_o, '0);
        end else begin
          want = pending_strip_q.pop_front();
          if (led_word_o !== want.word) report_mismatch("led_word", led_word_o, want.word);
          if (last_o !== want.last) report_mismatch("last", {31'd0, last_o}, {31'd0, want.last});
        end
        words_checked++;
        if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
        rx_hold = rx_steady ? 0 : $urandom_range(0, 3);
        if (hold_armed && !hold_done) begin
          rx_hold   = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_COLOR_LOW:  shade_regs.low  = data;
      CFG_COLOR_MID:  shade_regs.mid  = data;
      CFG_COLOR_HIGH: shade_regs.high = data;
      CFG_COLOR_OFF:  shade_regs.off  = data;
      CFG_REV_MASK:   flip_mask       = data[MASK_W-1:0];
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic set_palette(input logic [WORD_W-1:0] low_w, input logic [WORD_W-1:0] mid_w,
                             input logic [WORD_W-1:0] high_w, input logic [WORD_W-1:0] off_w,
                             input logic [WORD_W-1:0] mask_w);
    write_reg(CFG_COLOR_LOW, low_w);
    write_reg(CFG_COLOR_MID, mid_w);
    write_reg(CFG_COLOR_HIGH, high_w);
    write_reg(CFG_COLOR_OFF, off_w);
    write_reg(CFG_REV_MASK, mask_w);
    settings_used++;
  endtask

  // Wait until every level is taken and every LED word has come out
  task automatic wait_drained();
    while (level_q.size() != 0 || in_valid_i || pending_strip_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly levels in range, some on colour and lit-count boundaries, some anything
  task automatic queue_random(input int count);
    int t;
    int base;
    logic [LEVEL_W-1:0] lvl;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: lvl = LEVEL_W'($urandom);
        1: begin
          t    = $urandom_range(0, BEAM_LENGTH);
          base = (t * FULL_LEVEL + BEAM_LENGTH - 1) / BEAM_LENGTH;
          lvl  = LEVEL_W'(base - $urandom_range(0, 1));
        end
        default: lvl = LEVEL_W'($urandom_range(0, FULL_LEVEL));
      endcase
      level_q.push_back(lvl);
    end
  endtask

  initial begin
    shade_regs = '0;
    flip_mask  = REVERSE_MASK_RST;
    beam_no    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset colours and mask: one full frame
    settings_used++;
    level_q = '{16'd0, 16'd25600, 16'hffff, 16'd1, 16'd12800, 16'd7877, 16'd17724,
                16'd25599, 16'd9846};
    wait_drained();

    // All beams reversed; out-of-range indexes must not disturb anything
    set_palette(32'h00ff_0011, 32'h0022_ff00, 32'hff00_3300, 32'h0101_0101, 32'h0000_01ff);
    write_reg(CFG_IDX_SPARE, 32'hdead_beef);
    write_reg(CFG_IDX_TOP, 32'h1234_5678);
    level_q = '{16'd1969, 16'd1970, 16'd7876, 16'd9847, 16'd15753, 16'd15754, 16'd17723,
                16'd25601, 16'd32768, 16'h5555, 16'haaaa, 16'h8000};
    wait_drained();

    // Extreme words, mask cleared with junk above its width
    set_palette(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_fe00);
    queue_random(60);
    hold_armed = 1'b1;
    wait_drained();

    set_palette($urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(50);
    wait_drained();

    set_palette(32'h0000_0000, 32'hffff_ffff, $urandom, 32'hffff_ffff, 32'h0000_01ff);
    queue_random(40);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_strip_q.size() != 0) begin
      report_mismatch("LED words never produced", pending_strip_q.size(), '0);
    end

    $display("Rendered %0d beam levels into %0d LED words under %0d register settings",
             levels_taken, words_checked, settings_used);
    $display("(%0d register writes, long output hold %0s)", regs_written,
             hold_done ? "applied" : "missed");
    if (mismatch_count == 0) begin
      $display("led_bar_graph_renderer verification clean");
    end else begin
      $display("led_bar_graph_renderer verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #RUN_LIMIT_NS;
    $display("Timed out with %0d LED words outstanding", pending_strip_q.size());
    $display("led_bar_graph_renderer verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: led_bar_graph_renderer.f
hdl/lbg_pkg.sv
hdl/lbg_in.sv
hdl/lbg_emit.sv
hdl/led_bar_graph_renderer.sv
dv/tb.sv
